// ----- rtl/imu_frame_deframer_tlv_splitter_defines.svh -----
// ----------------------------------------------------------------------------
// imu frame deframer assertion macros
// shared concurrent assertion forms used by the deframer modules
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_DEFRAMER_TLV_SPLITTER_DEFINES_SVH
`define IMU_FRAME_DEFRAMER_TLV_SPLITTER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define IFDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define IFDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ifds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifds_pkg
// types and constants shared by the frame deframer and block splitter
// ----------------------------------------------------------------------------
package ifds_pkg;

  // frame framing bytes
  localparam logic [7:0] PREAMBLE_BYTE = 8'hFA;
  localparam logic [7:0] BUS_BYTE      = 8'hFF;
  localparam logic [7:0] EXT_LEN_BYTE  = 8'hFF;

  // frame size rules
  localparam int unsigned HDR_STD       = 4;
  localparam int unsigned HDR_EXT       = 6;
  localparam int unsigned MIN_FRAME     = 5;
  localparam int unsigned MIN_EXT_FRAME = 7;

  // saturating byte counter
  localparam int unsigned     COUNT_W   = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_ID_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_ID_B = 2'd1;

  // register reset values
  localparam logic [7:0] MSG_ID_A_RST = 8'd54;
  localparam logic [7:0] MSG_ID_B_RST = 8'd50;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_t;

  // frame verdict codes, lower code wins, but a bad preamble beats a short extended frame
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_PRE   = 3'd2,
    ST_LEN_MISM  = 3'd3,
    ST_BAD_TYPE  = 3'd4,
    ST_CHECKSUM  = 3'd5
  } status_t;

  // block splitter phase
  typedef enum logic [3:0] {
    PH_ID_HI = 4'b0001,
    PH_ID_LO = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_DATA  = 4'b1000
  } phase_t;

  // classified result passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [15:0] block_id;
    logic [7:0]  blen;
    logic [7:0]  pbyte;
    logic [7:0]  pindex;
    logic        last;
    status_t     status;
    logic        overrun;
  } rec_t;

endpackage

// ----- rtl/ifds_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifds_front
// parses one frame byte per cycle unless the queue is full; pushes header, data and verdict records
// ----------------------------------------------------------------------------
`include "imu_frame_deframer_tlv_splitter_defines.svh"

module ifds_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,
  input  logic                            in_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ifds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            q_full,
  output logic                            q_push,
  output ifds_pkg::rec_t                  q_rec
);
  import ifds_pkg::*;

  logic               in_fire;
  logic [7:0]         b;

  // frame state
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [7:0]         sum_r, sum_nxt, sum_upd;
  logic               good_r, good_nxt, good_upd;
  logic [7:0]         msgid_r, msgid_nxt, msgid_upd;
  logic [7:0]         lenbyte_r, lenbyte_nxt, lenbyte_upd;
  logic [15:0]        plen_r, plen_nxt, plen_upd;
  logic [15:0]        offset_r, offset_nxt, offset_upd;
  phase_t             phase_r, phase_nxt, phase_upd;
  logic [15:0]        id_r, id_nxt, id_upd;
  logic [7:0]         clen_r, clen_nxt, clen_upd;
  logic [7:0]         bpos_r, bpos_nxt, bpos_upd;
  logic               stop_r, stop_nxt, stop_upd;

  // accepted message ids
  logic [7:0]         msg_a_r, msg_b_r;

  // per-byte decode
  logic               ext;
  logic               blk_last;
  logic               blk_push;
  rec_t               blk_rec;
  logic [COUNT_W:0]   total;
  logic [COUNT_W:0]   expect_total;
  status_t            status;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign cfg_ready = 1'b1;
  assign ext       = (lenbyte_r == EXT_LEN_BYTE);
  assign blk_last  = (({1'b0, bpos_r} + 9'd1) == {1'b0, clen_r});

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_a_r <= MSG_ID_A_RST;
      msg_b_r <= MSG_ID_B_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MSG_ID_A: msg_a_r <= cfg_data;
        CFG_MSG_ID_B: msg_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // header fields, payload region and block splitting for one byte
  always_comb begin
    sum_upd     = sum_r;
    good_upd    = good_r;
    msgid_upd   = msgid_r;
    lenbyte_upd = lenbyte_r;
    plen_upd    = plen_r;
    offset_upd  = offset_r;
    phase_upd   = phase_r;
    id_upd      = id_r;
    clen_upd    = clen_r;
    bpos_upd    = bpos_r;
    stop_upd    = stop_r;
    blk_push    = 1'b0;
    blk_rec     = '0;

    if (count_r != '0) begin
      sum_upd = sum_r + b;
    end

    if (count_r == COUNT_W'(0)) begin
      if (b != PREAMBLE_BYTE) good_upd = 1'b0;
    end else if (count_r == COUNT_W'(1)) begin
      if (b != BUS_BYTE) good_upd = 1'b0;
    end else if (count_r == COUNT_W'(2)) begin
      msgid_upd = b;
    end else if (count_r == COUNT_W'(3)) begin
      lenbyte_upd = b;
      plen_upd    = (b == EXT_LEN_BYTE) ? 16'd0 : {8'd0, b};
    end else if ((count_r == COUNT_W'(4)) && ext) begin
      plen_upd = {b, 8'd0};
    end else if ((count_r == COUNT_W'(5)) && ext) begin
      plen_upd = {plen_r[15:8], b};
    end else if (offset_r < plen_r) begin
      if (!stop_r) begin
        case (phase_r)
          PH_ID_HI: begin
            id_upd    = {b, 8'd0};
            phase_upd = PH_ID_LO;
          end
          PH_ID_LO: begin
            id_upd    = {id_r[15:8], b};
            phase_upd = PH_LEN;
          end
          PH_LEN: begin
            clen_upd = b;
            if (({1'b0, offset_r} + 17'd1 + {9'd0, b}) > {1'b0, plen_r}) begin
              stop_upd = 1'b1;
            end else begin
              blk_push          = 1'b1;
              blk_rec.kind      = KIND_HDR;
              blk_rec.block_id  = id_r;
              blk_rec.blen      = b;
              bpos_upd          = 8'd0;
              phase_upd         = (b != 8'd0) ? PH_DATA : PH_ID_HI;
            end
          end
          PH_DATA: begin
            blk_push          = 1'b1;
            blk_rec.kind      = KIND_DATA;
            blk_rec.block_id  = id_r;
            blk_rec.blen      = clen_r;
            blk_rec.pbyte     = b;
            blk_rec.pindex    = bpos_r;
            blk_rec.last      = blk_last;
            bpos_upd          = bpos_r + 8'd1;
            if (blk_last) phase_upd = PH_ID_HI;
          end
          default: phase_upd = PH_ID_HI;
        endcase
      end
      offset_upd = offset_r + 16'd1;
    end
  end

  // frame verdict in priority order
  assign total        = {1'b0, count_r} + (COUNT_W+1)'(1);
  assign expect_total = (COUNT_W+1)'(plen_upd) + (COUNT_W+1)'(ext ? HDR_EXT : HDR_STD)
                      + (COUNT_W+1)'(1);

  always_comb begin
    if (total < (COUNT_W+1)'(MIN_FRAME)) begin
      status = ST_SHORT;
    end else if (!good_upd) begin
      status = ST_BAD_PRE;
    end else if (ext && (total < (COUNT_W+1)'(MIN_EXT_FRAME))) begin
      status = ST_SHORT;
    end else if (total != expect_total) begin
      status = ST_LEN_MISM;
    end else if ((msgid_upd != msg_a_r) && (msgid_upd != msg_b_r)) begin
      status = ST_BAD_TYPE;
    end else if (sum_upd != 8'd0) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_OK;
    end
  end

  // next state and queue push
  always_comb begin
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    good_nxt    = good_r;
    msgid_nxt   = msgid_r;
    lenbyte_nxt = lenbyte_r;
    plen_nxt    = plen_r;
    offset_nxt  = offset_r;
    phase_nxt   = phase_r;
    id_nxt      = id_r;
    clen_nxt    = clen_r;
    bpos_nxt    = bpos_r;
    stop_nxt    = stop_r;
    q_push      = 1'b0;
    q_rec       = blk_rec;

    if (in_fire) begin
      if (in_tlast) begin
        // verdict, then the frame starts over
        q_push         = 1'b1;
        q_rec          = '0;
        q_rec.kind     = KIND_VERDICT;
        q_rec.status   = status;
        q_rec.overrun  = stop_upd;
        count_nxt      = '0;
        sum_nxt        = 8'd0;
        good_nxt       = 1'b1;
        msgid_nxt      = 8'd0;
        lenbyte_nxt    = 8'd0;
        plen_nxt       = 16'd0;
        offset_nxt     = 16'd0;
        phase_nxt      = PH_ID_HI;
        id_nxt         = 16'd0;
        clen_nxt       = 8'd0;
        bpos_nxt       = 8'd0;
        stop_nxt       = 1'b0;
      end else begin
        q_push      = blk_push;
        sum_nxt     = sum_upd;
        good_nxt    = good_upd;
        msgid_nxt   = msgid_upd;
        lenbyte_nxt = lenbyte_upd;
        plen_nxt    = plen_upd;
        offset_nxt  = offset_upd;
        phase_nxt   = phase_upd;
        id_nxt      = id_upd;
        clen_nxt    = clen_upd;
        bpos_nxt    = bpos_upd;
        stop_nxt    = stop_upd;
        if (count_r != COUNT_MAX) count_nxt = count_r + COUNT_W'(1);
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      sum_r     <= 8'd0;
      good_r    <= 1'b1;
      msgid_r   <= 8'd0;
      lenbyte_r <= 8'd0;
      plen_r    <= 16'd0;
      offset_r  <= 16'd0;
      phase_r   <= PH_ID_HI;
      id_r      <= 16'd0;
      clen_r    <= 8'd0;
      bpos_r    <= 8'd0;
      stop_r    <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      sum_r     <= sum_nxt;
      good_r    <= good_nxt;
      msgid_r   <= msgid_nxt;
      lenbyte_r <= lenbyte_nxt;
      plen_r    <= plen_nxt;
      offset_r  <= offset_nxt;
      phase_r   <= phase_nxt;
      id_r      <= id_nxt;
      clen_r    <= clen_nxt;
      bpos_r    <= bpos_nxt;
      stop_r    <= stop_nxt;
    end
  end

  // parser checks
  `IFDS_ASSERT_NEXT(a_end_restarts_frame, in_fire && in_tlast, count_r == '0, "frame not restarted after last beat")
  `IFDS_ASSERT(a_stop_holds_len_phase, !stop_r || (phase_r == PH_LEN), "parsing stopped outside length phase")
  `IFDS_ASSERT(a_data_phase_nonzero_len, (phase_r != PH_DATA) || (clen_r != 8'd0), "data phase with zero block length")

endmodule

// ----- rtl/ifds_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifds_queue
// small first-in first-out queue of classified records between front and back
// ----------------------------------------------------------------------------
`include "imu_frame_deframer_tlv_splitter_defines.svh"

module ifds_queue #(
  parameter int unsigned DEPTH = ifds_pkg::QUEUE_DEPTH  // power of two, at least 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ifds_pkg::rec_t push_rec,
  input  logic           pop,
  output ifds_pkg::rec_t pop_rec,
  output logic           full,
  output logic           not_empty
);
  import ifds_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rec_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_rec   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (!push && pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

  // queue checks
  `IFDS_ASSERT(a_no_overflow, !(push && full), "push into full queue")
  `IFDS_ASSERT(a_no_underflow, !(pop && !not_empty), "pop from empty queue")
  `IFDS_ASSERT(a_count_bound, cnt_r <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// ----- rtl/ifds_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifds_back
// formats queued records into result beats and holds them in the output register
// ----------------------------------------------------------------------------
module ifds_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ifds_pkg::rec_t q_rec,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [47:0]    out_tdata,
  output logic [1:0]     out_tuser,
  output logic           out_tlast
);
  import ifds_pkg::*;

  logic        valid_r;
  logic [47:0] data_r, data_nxt;
  logic [1:0]  user_r;
  logic        last_r, last_nxt;

  // load the output register when empty or being taken
  assign q_pop = q_valid && (!valid_r || out_tready);

  // per-kind field selection, unused fields read as zero
  always_comb begin
    data_nxt = '0;
    last_nxt = 1'b0;
    case (q_rec.kind)
      KIND_HDR: begin
        data_nxt[15:0]  = q_rec.block_id;
        data_nxt[23:16] = q_rec.blen;
      end
      KIND_DATA: begin
        data_nxt[15:0]  = q_rec.block_id;
        data_nxt[23:16] = q_rec.blen;
        data_nxt[31:24] = q_rec.pbyte;
        data_nxt[39:32] = q_rec.pindex;
        last_nxt        = q_rec.last;
      end
      KIND_VERDICT: begin
        data_nxt[40]    = (q_rec.status == ST_OK);
        data_nxt[43:41] = q_rec.status;
        data_nxt[44]    = q_rec.overrun;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= data_nxt;
      user_r <= q_rec.kind;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

// ----- rtl/imu_frame_deframer_tlv_splitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_deframer_tlv_splitter
// checks serial bus frames and splits their payload into id/length/value blocks
// ----------------------------------------------------------------------------
// Input: one frame byte per beat on in_tdata, in_tlast on the frame's last byte.
// Output: one beat per block header (tuser 0), per block payload byte (tuser 1)
// and per frame verdict (tuser 2, on the beat for the last byte); block
// beats of a frame whose verdict fails are to be discarded downstream.
// Config: cfg_index 0 and 1 set the two accepted message ids; write only
// while no frame byte is in flight.
// Throughput: one byte per cycle while the queue is not full; the front parses
// each byte as it is accepted and a queue of QUEUE_DEPTH records decouples it
// from the output register. A result is written into the queue when its byte
// is accepted, then loaded into the output register that drives out_tvalid.
// Stall: with out_tready low the output register holds, the queue fills and
// in_tready drops once it is full; nothing is dropped.
// Reset: frame state cleared, accepted ids back to 54 and 50, queue empty;
// no clearing pass, bytes are taken right after reset.
// ----------------------------------------------------------------------------
module imu_frame_deframer_tlv_splitter #(
  parameter int unsigned QUEUE_DEPTH = ifds_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] block_id, [23:16] block_length, [31:24] payload_byte,
  // [39:32] payload_index, [40] frame_ok, [43:41] frame_status,
  // [44] block_overrun, [47:45] zero
  output logic [47:0]                    out_tdata,
  output logic [1:0]                     out_tuser,  // [1:0] out_kind
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ifds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import ifds_pkg::*;

  logic q_push, q_pop, q_full, q_not_empty;
  rec_t push_rec, pop_rec;

  ifds_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (push_rec)
  );

  ifds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (push_rec),
    .pop       (q_pop),
    .pop_rec   (pop_rec),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  ifds_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_rec      (pop_rec),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
